FILE: rtl/pbt_pkg.sv
package pbt_pkg;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_POINT  = 2'd2,
      OP_BOX    = 2'd3
   } op_type;

   localparam logic [1:0] REL_SEPARATE  = 2'd0;
   localparam logic [1:0] REL_OVERLAP   = 2'd1;
   localparam logic [1:0] REL_CONTAINED = 2'd2;

   typedef struct packed {
      logic clear;
      logic append;
   } store_ctl_type;

endpackage

FILE: rtl/pbt_store.sv
module pbt_store #(
   parameter int MAX_VERTICES = 64,
   parameter int COORD_BITS   = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  pbt_pkg::store_ctl_type                 ctl,
   input  logic signed [COORD_BITS-1:0]           wr_x,
   input  logic signed [COORD_BITS-1:0]           wr_y,
   input  logic [$clog2(MAX_VERTICES)-1:0]        rd_addr,
   output logic signed [COORD_BITS-1:0]           rd_x,
   output logic signed [COORD_BITS-1:0]           rd_y,
   output logic [$clog2(MAX_VERTICES+1)-1:0]      count,
   output logic                                   full,
   output logic signed [COORD_BITS-1:0]           min_x,
   output logic signed [COORD_BITS-1:0]           min_y,
   output logic signed [COORD_BITS-1:0]           max_x,
   output logic signed [COORD_BITS-1:0]           max_y
);

   localparam int IW = $clog2(MAX_VERTICES);
   localparam int CW = $clog2(MAX_VERTICES + 1);
   localparam logic signed [COORD_BITS-1:0] TOP = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [COORD_BITS-1:0] BOT = {1'b1, {(COORD_BITS-1){1'b0}}};

   logic signed [COORD_BITS-1:0] mem_x [MAX_VERTICES];
   logic signed [COORD_BITS-1:0] mem_y [MAX_VERTICES];
   logic [CW-1:0] count_ff;
   logic signed [COORD_BITS-1:0] min_x_ff, min_y_ff, max_x_ff, max_y_ff;
   logic signed [COORD_BITS-1:0] rd_x_ff, rd_y_ff;

   assign full  = (count_ff == CW'(MAX_VERTICES));
   assign count = count_ff;
   assign min_x = min_x_ff;
   assign min_y = min_y_ff;
   assign max_x = max_x_ff;
   assign max_y = max_y_ff;
   assign rd_x  = rd_x_ff;
   assign rd_y  = rd_y_ff;

   always_ff @(posedge clock) begin
      rd_x_ff <= mem_x[rd_addr];
      rd_y_ff <= mem_y[rd_addr];
      if (ctl.append && !full) begin
         mem_x[count_ff[IW-1:0]] <= wr_x;
         mem_y[count_ff[IW-1:0]] <= wr_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         count_ff <= '0;
         min_x_ff <= TOP;
         min_y_ff <= TOP;
         max_x_ff <= BOT;
         max_y_ff <= BOT;
      end else if (ctl.append && !full) begin
         count_ff <= count_ff + CW'(1);
         if (wr_x < min_x_ff) min_x_ff <= wr_x;
         if (wr_x > max_x_ff) max_x_ff <= wr_x;
         if (wr_y < min_y_ff) min_y_ff <= wr_y;
         if (wr_y > max_y_ff) max_y_ff <= wr_y;
      end
   end

endmodule

FILE: rtl/pbt_cmp.sv
module pbt_cmp #(
   parameter int FW = 33
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [FW-1:0] a,
   input  logic signed [FW-1:0] b,
   input  logic signed [FW-1:0] c,
   input  logic signed [FW-1:0] d,
   output logic                 done,
   output logic                 less
);

   // a*b < c*d, one shared multiplier used for both products
   typedef enum logic [1:0] {S_IDLE, S_M1, S_M2, S_RES} state_type;

   state_type state_ff;
   logic signed [FW-1:0] a_ff, b_ff, c_ff, d_ff;
   logic signed [2*FW-1:0] prod_ff, first_ff, prod_c;
   logic signed [FW-1:0] mx, my;

   assign mx     = (state_ff == S_M1) ? a_ff : c_ff;
   assign my     = (state_ff == S_M1) ? b_ff : d_ff;
   assign prod_c = mx * my;
   assign done   = (state_ff == S_RES);
   assign less   = first_ff < prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  a_ff <= a;
                  b_ff <= b;
                  c_ff <= c;
                  d_ff <= d;
                  state_ff <= S_M1;
               end
            end
            S_M1: begin
               prod_ff  <= prod_c;
               state_ff <= S_M2;
            end
            S_M2: begin
               first_ff <= prod_ff;
               prod_ff  <= prod_c;
               state_ff <= S_RES;
            end
            S_RES: state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

FILE: rtl/polygon_point_and_box_test.sv
// Point and box tests against a stored polygon. A clear, an append, a query
// rejected by the bounding box and a query against an empty polygon are answered
// straight from the idle state. Otherwise a query walks the N stored vertices one
// edge at a time, a box query stopping early when an edge is found to overlap the
// box. Its run time is set by the single shared multiply-compare unit, which does
// each exact product comparison, and by the one-read-a-cycle vertex memory. One
// transaction is worked on at a time; the next is taken once the result has been
// delivered.
module polygon_point_and_box_test #(
   parameter int MAX_VERTICES = 64,
   parameter int COORD_BITS   = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_operation,
   input  logic signed [COORD_BITS-1:0]         req_pos_x,
   input  logic signed [COORD_BITS-1:0]         req_pos_y,
   input  logic signed [COORD_BITS-1:0]         req_far_x,
   input  logic signed [COORD_BITS-1:0]         req_far_y,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_inside_res,
   output logic [1:0]                           rsp_relation,
   output logic [$clog2(MAX_VERTICES+1)-1:0]    rsp_vertex_count,
   output logic                                 rsp_full_error
);

   localparam int IW = $clog2(MAX_VERTICES);
   localparam int CW = $clog2(MAX_VERTICES + 1);
   localparam int FW = COORD_BITS + 1;
   localparam logic signed [FW-1:0] ZERO = '0;
   localparam logic signed [FW-1:0] ONE  = FW'(1);

   typedef enum logic [3:0] {
      S_IDLE, S_LOADP, S_FETCH, S_EDGE, S_CLIP, S_CLIPW,
      S_FINAL, S_FINALW, S_CROSS, S_CROSSW
   } state_type;

   state_type state_ff;
   logic box_ff;
   logic [IW-1:0] idx_ff;
   logic [1:0] step_ff;
   logic cnt_ff;
   logic tgt_l0_ff;
   logic signed [COORD_BITS-1:0] qx_ff, qy_ff, hx_ff, hy_ff;
   logic signed [COORD_BITS-1:0] px_ff, py_ff, cx_ff, cy_ff;
   logic signed [FW-1:0] l0n_ff, l0d_ff, l1n_ff, l1d_ff, fn_ff, fd_ff;
   logic rsp_valid_ff, inside_ff, full_ff;
   logic [1:0] rel_ff;

   pbt_pkg::store_ctl_type ctl;
   logic accept;
   logic [IW-1:0] rd_addr;
   logic signed [COORD_BITS-1:0] rd_x, rd_y, bmin_x, bmin_y, bmax_x, bmax_y;
   logic [CW-1:0] count;
   logic full;
   logic [CW-1:0] last;

   logic cmp_start, cmp_done, cmp_less;
   logic signed [FW-1:0] ca, cb, cc, cd;

   logic point_reject, box_reject;
   logic sd, shi, outside, c_in, c_out;
   logic signed [COORD_BITS-1:0] pd, cdd, bd;
   logic signed [FW-1:0] rnum, rden, fnum, fden;
   logic cross1, cross2;
   logic last_edge;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign ctl.clear  = accept && (req_operation == pbt_pkg::OP_CLEAR);
   assign ctl.append = accept && (req_operation == pbt_pkg::OP_APPEND);
   assign last      = count - CW'(1);
   assign rd_addr   = (state_ff == S_IDLE) ? last[IW-1:0] : idx_ff;
   assign last_edge = (idx_ff == last[IW-1:0]);

   pbt_store #(.MAX_VERTICES(MAX_VERTICES), .COORD_BITS(COORD_BITS)) u_store (
      .clock(clock), .reset(reset), .ctl(ctl), .wr_x(req_pos_x), .wr_y(req_pos_y),
      .rd_addr(rd_addr), .rd_x(rd_x), .rd_y(rd_y), .count(count), .full(full),
      .min_x(bmin_x), .min_y(bmin_y), .max_x(bmax_x), .max_y(bmax_y)
   );

   pbt_cmp #(.FW(FW)) u_cmp (
      .clock(clock), .reset(reset), .start(cmp_start),
      .a(ca), .b(cb), .c(cc), .d(cd), .done(cmp_done), .less(cmp_less)
   );

   assign point_reject = (count == '0) || (req_pos_x < bmin_x) || (req_pos_x > bmax_x) ||
                         (req_pos_y < bmin_y) || (req_pos_y > bmax_y);
   assign box_reject   = (count == '0) || (bmin_x > req_far_x) || (req_pos_x > bmax_x) ||
                         (bmin_y > req_far_y) || (req_pos_y > bmax_y);

   // clip step: bit 1 picks the axis, bit 0 the high side of the box
   assign sd   = step_ff[1];
   assign shi  = step_ff[0];
   assign pd   = sd ? py_ff : px_ff;
   assign cdd  = sd ? cy_ff : cx_ff;
   assign bd   = shi ? (sd ? hy_ff : hx_ff) : (sd ? qy_ff : qx_ff);
   assign outside = shi ? (pd > bd) : (pd < bd);
   assign c_in    = shi ? (cdd <= bd) : (cdd >= bd);
   assign c_out   = shi ? (cdd > bd) : (cdd < bd);
   assign rnum = FW'(bd) - FW'(pd);
   assign rden = FW'(cdd) - FW'(pd);
   assign fnum = rden[FW-1] ? -rnum : rnum;
   assign fden = rden[FW-1] ? -rden : rden;

   assign cross1 = (py_ff <= qy_ff) && (cy_ff > qy_ff);
   assign cross2 = (py_ff > qy_ff) && (cy_ff <= qy_ff);

   always_comb begin
      cmp_start = 1'b0;
      ca = l0n_ff;
      cb = l1d_ff;
      cc = l1n_ff;
      cd = l0d_ff;
      case (state_ff)
         S_CLIP: begin
            if (outside && c_in) begin
               cmp_start = 1'b1;
               ca = l0n_ff;
               cb = fden;
               cc = fnum;
               cd = l0d_ff;
            end else if (!outside && c_out) begin
               cmp_start = 1'b1;
               ca = fnum;
               cb = l1d_ff;
               cc = l1n_ff;
               cd = fden;
            end
         end
         S_FINAL: cmp_start = 1'b1;
         S_CROSS: begin
            if (cross1) begin
               cmp_start = 1'b1;
               ca = FW'(qx_ff) - FW'(px_ff);
               cb = FW'(cy_ff) - FW'(py_ff);
               cc = FW'(qy_ff) - FW'(py_ff);
               cd = FW'(cx_ff) - FW'(px_ff);
            end else if (cross2) begin
               cmp_start = 1'b1;
               ca = FW'(qx_ff) - FW'(cx_ff);
               cb = FW'(py_ff) - FW'(cy_ff);
               cc = FW'(qy_ff) - FW'(cy_ff);
               cd = FW'(px_ff) - FW'(cx_ff);
            end
         end
         default: cmp_start = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  qx_ff     <= req_pos_x;
                  qy_ff     <= req_pos_y;
                  hx_ff     <= req_far_x;
                  hy_ff     <= req_far_y;
                  box_ff    <= (req_operation == pbt_pkg::OP_BOX);
                  idx_ff    <= '0;
                  cnt_ff    <= 1'b0;
                  inside_ff <= 1'b0;
                  rel_ff    <= pbt_pkg::REL_SEPARATE;
                  full_ff   <= (req_operation == pbt_pkg::OP_APPEND) && full;
                  if (((req_operation == pbt_pkg::OP_POINT) && !point_reject) ||
                      ((req_operation == pbt_pkg::OP_BOX) && !box_reject)) begin
                     state_ff <= S_LOADP;
                  end else begin
                     rsp_valid_ff <= 1'b1;
                  end
               end
            end
            S_LOADP: begin
               px_ff    <= rd_x;
               py_ff    <= rd_y;
               state_ff <= S_EDGE;
            end
            S_FETCH: state_ff <= S_EDGE;
            S_EDGE: begin
               cx_ff   <= rd_x;
               cy_ff   <= rd_y;
               l0n_ff  <= ZERO;
               l0d_ff  <= ONE;
               l1n_ff  <= ONE;
               l1d_ff  <= ONE;
               step_ff <= '0;
               state_ff <= box_ff ? S_CLIP : S_CROSS;
            end
            S_CLIP: begin
               fn_ff     <= fnum;
               fd_ff     <= fden;
               tgt_l0_ff <= outside;
               if (cmp_start) begin
                  state_ff <= S_CLIPW;
               end else begin
                  if (outside) begin
                     l0n_ff <= ONE;
                     l0d_ff <= ONE;
                  end
                  step_ff <= step_ff + 2'd1;
                  if (step_ff == 2'd3) state_ff <= S_FINAL;
               end
            end
            S_CLIPW: begin
               if (cmp_done) begin
                  if (cmp_less) begin
                     if (tgt_l0_ff) begin
                        l0n_ff <= fn_ff;
                        l0d_ff <= fd_ff;
                     end else begin
                        l1n_ff <= fn_ff;
                        l1d_ff <= fd_ff;
                     end
                  end
                  step_ff  <= step_ff + 2'd1;
                  state_ff <= (step_ff == 2'd3) ? S_FINAL : S_CLIP;
               end
            end
            S_FINAL: state_ff <= S_FINALW;
            S_FINALW: begin
               if (cmp_done) begin
                  if (cmp_less) begin
                     rel_ff       <= pbt_pkg::REL_OVERLAP;
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= S_IDLE;
                  end else begin
                     state_ff <= S_CROSS;
                  end
               end
            end
            S_CROSS: begin
               if (cmp_start) begin
                  state_ff <= S_CROSSW;
               end else begin
                  px_ff <= cx_ff;
                  py_ff <= cy_ff;
                  if (last_edge) begin
                     inside_ff    <= !box_ff && cnt_ff;
                     rel_ff       <= (box_ff && cnt_ff) ? pbt_pkg::REL_CONTAINED
                                                        : pbt_pkg::REL_SEPARATE;
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= S_IDLE;
                  end else begin
                     idx_ff   <= idx_ff + IW'(1);
                     state_ff <= S_FETCH;
                  end
               end
            end
            S_CROSSW: begin
               if (cmp_done) begin
                  px_ff  <= cx_ff;
                  py_ff  <= cy_ff;
                  cnt_ff <= cnt_ff ^ cmp_less;
                  if (last_edge) begin
                     inside_ff    <= !box_ff && (cnt_ff ^ cmp_less);
                     rel_ff       <= (box_ff && (cnt_ff ^ cmp_less)) ?
                                     pbt_pkg::REL_CONTAINED : pbt_pkg::REL_SEPARATE;
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= S_IDLE;
                  end else begin
                     idx_ff   <= idx_ff + IW'(1);
                     state_ff <= S_FETCH;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_inside_res   = inside_ff;
   assign rsp_relation     = rel_ff;
   assign rsp_vertex_count = count;
   assign rsp_full_error   = full_ff;

endmodule
